/* rtl/ims_pkg.sv */
// Shared widths, reset values and register codes of the Ising spin update block.
package ims_pkg;

   localparam int ROW_W            = 6;
   localparam int COL_W            = 6;
   localparam int FRACTION_W       = 16;
   localparam int TOTAL_W          = 14;
   localparam int SIDE_CSR_W       = 7;
   localparam int CSR_INDEX_W      = 2;
   localparam int CSR_DATA_W       = 16;
   localparam int MAX_SIDE_DEFAULT = 64;
   localparam int SIDE_RESET       = 64;
   localparam int SIDE_MIN         = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LATTICE_SIDE   = 2'd0,
      CSR_THRESHOLD_LOW  = 2'd1,
      CSR_THRESHOLD_HIGH = 2'd2
   } csr_index_type;

endpackage

/* rtl/ims_if.sv */
// Channel interfaces of the Ising spin update block: request, response and register write.
interface ims_req_if;
   import ims_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ROW_W-1:0]      row;
   logic [COL_W-1:0]      column;
   logic [FRACTION_W-1:0] random_fraction;

   modport source (output valid, row, column, random_fraction, input ready);
   modport sink   (input valid, row, column, random_fraction, output ready);
endinterface

interface ims_rsp_if;
   import ims_pkg::*;

   logic                      valid;
   logic                      ready;
   logic                      flipped;
   logic                      new_spin;
   logic signed [TOTAL_W-1:0] spin_total;

   modport source (output valid, flipped, new_spin, spin_total, input ready);
   modport sink   (input valid, flipped, new_spin, spin_total, output ready);
endinterface

interface ims_csr_if;
   import ims_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/ising_metropolis_spin_update.sv */
// Metropolis update of one site of a periodic square Ising lattice per request transaction.
// The block takes one site trial per clock cycle unless it stalls as described below, and
// presents its response from the output register: the accepting edge reads the site row and
// the rows above and below from three identical copies of the lattice memory (one read port
// each, with a bypass of the row written at the same edge); when the update stage advances,
// it forms the energy change, decides the flip, writes the row back and loads the output
// register. The response register lets the next request enter while a response waits; a
// request stalls only while both the update stage and the output register are full and the
// response is not taken. Writing lattice_side restarts the lattice at once by clearing one
// valid bit per row, so there is no clearing pass and no dead time after reset or restart.
// Sides outside 2 to MAX_SIDE are clamped; sites outside the active side change nothing and
// report no flip, a spin of zero and the unchanged total.
module ising_metropolis_spin_update #(
   parameter int MAX_SIDE = ims_pkg::MAX_SIDE_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ims_req_if.sink   req_bus,
   ims_rsp_if.source rsp_bus,
   ims_csr_if.sink   csr_bus
);
   import ims_pkg::*;

   localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
   localparam int IDX_W      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int POS_W      = (ROW_W > COL_W) ? ROW_W : COL_W;
   localparam int CW         = (SIDE_W > POS_W) ? SIDE_W : POS_W;
   localparam int SQ_W       = 2 * SIDE_W;
   localparam int RESET_SIDE = (MAX_SIDE < SIDE_RESET) ? MAX_SIDE : SIDE_RESET;
   localparam int COPIES     = 3;
   localparam int COPY_UP    = 0;
   localparam int COPY_MID   = 1;
   localparam int COPY_DOWN  = 2;

   // Configuration.
   logic [SIDE_W-1:0]     side_ff;
   logic [FRACTION_W-1:0] thr_low_ff;
   logic [FRACTION_W-1:0] thr_high_ff;
   logic                  csr_write;
   logic                  side_write;
   logic [SIDE_W-1:0]     side_clamped;
   logic [SQ_W-1:0]       side_sq;

   // Lattice storage; a stored 1 means spin -1, so a row that is not valid reads as all +1.
   logic [MAX_SIDE-1:0]   row_valid_ff;
   logic [MAX_SIDE-1:0]   rd_data_ff [COPIES];
   logic                  rd_valid_ff [COPIES];
   logic [IDX_W-1:0]      rd_addr [COPIES];
   logic [MAX_SIDE-1:0]   row_w [COPIES];
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   logic [MAX_SIDE-1:0]   wr_data;

   // Request side.
   logic                  req_accept;
   logic [CW-1:0]         side_w;
   logic [CW-1:0]         req_row_w;
   logic [CW-1:0]         up_w;
   logic [CW-1:0]         down_w;

   // Update stage.
   logic                  s1_valid_ff;
   logic [ROW_W-1:0]      s1_row_ff;
   logic [COL_W-1:0]      s1_col_ff;
   logic [FRACTION_W-1:0] s1_fraction_ff;
   logic                  s1_advance;
   logic [CW-1:0]         s1_row_w;
   logic [CW-1:0]         s1_col_w;
   logic [CW-1:0]         left_w;
   logic [CW-1:0]         right_w;
   logic [IDX_W-1:0]      col_idx;
   logic                  s1_in_range;
   logic                  me;
   logic                  nb_up;
   logic                  nb_down;
   logic                  nb_left;
   logic                  nb_right;
   logic [2:0]            same_count;
   logic                  s1_flip;

   logic [TOTAL_W-1:0]    total_ff;
   logic [TOTAL_W-1:0]    total_in;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_flipped_ff;
   logic                  rsp_new_spin_ff;
   logic [TOTAL_W-1:0]    rsp_total_ff;

   assign csr_bus.ready = 1'b1;
   assign csr_write     = csr_bus.valid && csr_bus.ready;
   assign side_write    = csr_write && (csr_index_type'(csr_bus.index) == CSR_LATTICE_SIDE);

   always_comb begin
      if (int'(csr_bus.data[SIDE_CSR_W-1:0]) < SIDE_MIN) begin
         side_clamped = SIDE_W'(SIDE_MIN);
      end else if (int'(csr_bus.data[SIDE_CSR_W-1:0]) > MAX_SIDE) begin
         side_clamped = SIDE_W'(MAX_SIDE);
      end else begin
         side_clamped = SIDE_W'(csr_bus.data[SIDE_CSR_W-1:0]);
      end
      side_sq = SQ_W'(side_clamped) * SQ_W'(side_clamped);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff     <= SIDE_W'(RESET_SIDE);
         thr_low_ff  <= '0;
         thr_high_ff <= '0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_bus.index))
            CSR_LATTICE_SIDE: begin
               side_ff <= side_clamped;
            end
            CSR_THRESHOLD_LOW: begin
               thr_low_ff <= csr_bus.data[FRACTION_W-1:0];
            end
            CSR_THRESHOLD_HIGH: begin
               thr_high_ff <= csr_bus.data[FRACTION_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Row addresses of the site and its two vertical neighbors, wrapped on the active side.
   assign req_accept = req_bus.valid && req_bus.ready;
   assign side_w     = CW'(side_ff);
   assign req_row_w  = CW'(req_bus.row);

   always_comb begin
      up_w   = (req_row_w == '0) ? side_w - CW'(1) : req_row_w - CW'(1);
      down_w = (req_row_w + CW'(1) == side_w) ? '0 : req_row_w + CW'(1);
      rd_addr[COPY_UP]   = IDX_W'(up_w);
      rd_addr[COPY_MID]  = IDX_W'(req_row_w);
      rd_addr[COPY_DOWN] = IDX_W'(down_w);
   end

   always_ff @(posedge clock) begin
      if (reset || side_write) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[wr_addr] <= 1'b1;
      end
   end

   for (genvar k = 0; k < COPIES; k++) begin : g_copy
      logic [MAX_SIDE-1:0] lattice_mem [MAX_SIDE];

      // A read of the row written at the same edge returns the new row.
      always_ff @(posedge clock) begin
         if (wr_en) begin
            lattice_mem[wr_addr] <= wr_data;
         end
         if (req_accept) begin
            if (wr_en && (wr_addr == rd_addr[k])) begin
               rd_data_ff[k]  <= wr_data;
               rd_valid_ff[k] <= 1'b1;
            end else begin
               rd_data_ff[k]  <= lattice_mem[rd_addr[k]];
               rd_valid_ff[k] <= row_valid_ff[rd_addr[k]];
            end
         end
      end

      assign row_w[k] = rd_valid_ff[k] ? rd_data_ff[k] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_row_ff      <= req_bus.row;
         s1_col_ff      <= req_bus.column;
         s1_fraction_ff <= req_bus.random_fraction;
      end
   end

   assign s1_advance    = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;

   // Spin update: count neighbors aligned with the site; three aligned means an energy rise
   // of four, four aligned a rise of eight, fewer never raises the energy.
   always_comb begin
      s1_row_w    = CW'(s1_row_ff);
      s1_col_w    = CW'(s1_col_ff);
      s1_in_range = (s1_row_w < side_w) && (s1_col_w < side_w);
      left_w      = (s1_col_w == '0) ? side_w - CW'(1) : s1_col_w - CW'(1);
      right_w     = (s1_col_w + CW'(1) == side_w) ? '0 : s1_col_w + CW'(1);
      col_idx     = IDX_W'(s1_col_w);
      me          = row_w[COPY_MID][col_idx];
      nb_up       = row_w[COPY_UP][col_idx];
      nb_down     = row_w[COPY_DOWN][col_idx];
      nb_left     = row_w[COPY_MID][IDX_W'(left_w)];
      nb_right    = row_w[COPY_MID][IDX_W'(right_w)];
      same_count  = 3'(nb_up == me) + 3'(nb_down == me) + 3'(nb_left == me)
                  + 3'(nb_right == me);
      if (same_count == 3'd4) begin
         s1_flip = s1_in_range && (s1_fraction_ff < thr_high_ff);
      end else if (same_count == 3'd3) begin
         s1_flip = s1_in_range && (s1_fraction_ff < thr_low_ff);
      end else begin
         s1_flip = s1_in_range;
      end
      if (s1_flip) begin
         total_in = me ? total_ff + TOTAL_W'(2) : total_ff - TOTAL_W'(2);
      end else begin
         total_in = total_ff;
      end
   end

   assign wr_en   = s1_advance && s1_flip;
   assign wr_addr = IDX_W'(s1_row_ff);
   assign wr_data = row_w[COPY_MID] ^ (MAX_SIDE'(1) << col_idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= TOTAL_W'(RESET_SIDE * RESET_SIDE);
      end else if (side_write) begin
         total_ff <= TOTAL_W'(side_sq);
      end else if (s1_advance) begin
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_flipped_ff  <= s1_flip;
         rsp_new_spin_ff <= s1_in_range && !(me ^ s1_flip);
         rsp_total_ff    <= total_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.flipped    = rsp_flipped_ff;
   assign rsp_bus.new_spin   = rsp_new_spin_ff;
   assign rsp_bus.spin_total = rsp_total_ff;

`ifndef SYNTHESIS
   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> s1_valid_ff)
      else $error("accepted request transaction did not reach the update stage");

   a_stall_only_on_full_output: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_bus.valid && !rsp_bus.ready && s1_valid_ff)
      else $error("request stalled while the output side could move");

   a_total_holds_without_flip: assert property (@(posedge clock) disable iff (reset)
      !wr_en && !side_write |=> $stable(total_ff))
      else $error("spin total changed without a flip or restart");

   a_flip_within_lattice: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> !rsp_bus.flipped || $past(s1_in_range))
      else $error("flip reported for a site outside the active lattice");
`endif

endmodule

/* tb/sv/tb_ising_metropolis_spin_update.sv */
// Self-checking testbench of the Ising Metropolis spin update block.
module tb_ising_metropolis_spin_update;
   timeunit 1ns;
   timeprecision 1ps;

   import ims_pkg::*;

   localparam int GRID               = MAX_SIDE_DEFAULT;
   localparam int TRIALS_PER_CHUNK   = 110;
   localparam int RANDOM_PHASES      = 9;
   localparam int RSP_HOLD_CYCLES    = 80;
   localparam int SETTLE_CYCLES      = 4;
   localparam int MAX_REPORTED       = 10;
   localparam int KEEP_LATTICE       = -1;

   typedef struct packed {
      logic [ROW_W-1:0]      row;
      logic [COL_W-1:0]      column;
      logic [FRACTION_W-1:0] random_fraction;
   } site_trial_type;

   typedef struct packed {
      logic                      flipped;
      logic                      new_spin;
      logic signed [TOTAL_W-1:0] spin_total;
   } spin_outcome_type;

   logic clock;
   logic reset;

   ims_req_if req_bus ();
   ims_rsp_if rsp_bus ();
   ims_csr_if csr_bus ();

   ising_metropolis_spin_update dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Lattice state and settings as the block should hold them.
   bit                    spin_grid [GRID][GRID];
   int                    lattice_total;
   int                    active_side;
   logic [FRACTION_W-1:0] accept_low;
   logic [FRACTION_W-1:0] accept_high;

   site_trial_type   pending_trials[$];
   spin_outcome_type expected_outcomes[$];

   bit offer_open;
   bit hold_request;
   bit rsp_hold;
   int send_idle_pct;
   int rsp_stall_pct;
   int error_count;

   function automatic void restart_lattice(logic [SIDE_CSR_W-1:0] side_setting);
      int s;
      s = side_setting;
      if (s < SIDE_MIN) s = SIDE_MIN;
      if (s > GRID) s = GRID;
      active_side = s;
      foreach (spin_grid[r, c]) spin_grid[r][c] = 1'b1;
      lattice_total = s * s;
   endfunction

   function automatic void apply_register_write(csr_index_type idx,
                                                logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_LATTICE_SIDE:   restart_lattice(value[SIDE_CSR_W-1:0]);
         CSR_THRESHOLD_LOW:  accept_low = value;
         CSR_THRESHOLD_HIGH: accept_high = value;
         default: ;
      endcase
   endfunction

   function automatic int spin_value(int r, int c);
      return spin_grid[r][c] ? 1 : -1;
   endfunction

   // One Metropolis trial: updates the lattice copy and returns the response it causes.
   function automatic spin_outcome_type predict_trial(site_trial_type t);
      spin_outcome_type o;
      int r, c, up, down, west, east, me, neighbor_sum, energy_change;
      bit flip;
      r = t.row;
      c = t.column;
      o = '0;
      flip = 1'b0;
      if (r < active_side && c < active_side) begin
         up   = (r == 0) ? active_side - 1 : r - 1;
         down = (r + 1 == active_side) ? 0 : r + 1;
         west = (c == 0) ? active_side - 1 : c - 1;
         east = (c + 1 == active_side) ? 0 : c + 1;
         me = spin_value(r, c);
         neighbor_sum = spin_value(up, c) + spin_value(down, c)
                      + spin_value(r, west) + spin_value(r, east);
         energy_change = 2 * me * neighbor_sum;
         if (energy_change <= 0) flip = 1'b1;
         else if (energy_change == 4) flip = t.random_fraction < accept_low;
         else flip = t.random_fraction < accept_high;
         if (flip) begin
            spin_grid[r][c] = (me < 0);
            lattice_total += (me < 0) ? 2 : -2;
         end
         o.new_spin = spin_grid[r][c];
      end
      o.flipped = flip;
      o.spin_total = lattice_total[TOTAL_W-1:0];
      return o;
   endfunction

   function automatic site_trial_type random_trial();
      site_trial_type t;
      int limit;
      logic [FRACTION_W-1:0] bound;
      limit = active_side;
      t.random_fraction = FRACTION_W'($urandom_range(65535));
      if (limit < GRID && $urandom_range(99) < 8) begin
         if ($urandom_range(1)) begin
            t.row = ROW_W'($urandom_range(GRID - 1, limit));
            t.column = COL_W'($urandom_range(GRID - 1));
         end else begin
            t.row = ROW_W'($urandom_range(GRID - 1));
            t.column = COL_W'($urandom_range(GRID - 1, limit));
         end
      end else begin
         t.row = ROW_W'($urandom_range(limit - 1));
         t.column = COL_W'($urandom_range(limit - 1));
      end
      // Some draws land right on or just below a threshold to probe the strict bound.
      if ($urandom_range(99) < 15) begin
         bound = $urandom_range(1) ? accept_low : accept_high;
         t.random_fraction = (bound == 0) ? '0 : bound - FRACTION_W'($urandom_range(1));
      end
      return t;
   endfunction

   function automatic void queue_trial(int r, int c, logic [FRACTION_W-1:0] draw);
      site_trial_type t;
      t.row = ROW_W'(r);
      t.column = COL_W'(c);
      t.random_fraction = draw;
      pending_trials.push_back(t);
   endfunction

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_register_write(idx, value);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain_pipeline();
      while (pending_trials.size() != 0 || expected_outcomes.size() != 0 || offer_open)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   // Request driver: holds an offer until its transaction completes, idles at random.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!offer_open) begin
         if (pending_trials.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_bus.valid           <= 1'b1;
            req_bus.row             <= pending_trials[0].row;
            req_bus.column          <= pending_trials[0].column;
            req_bus.random_fraction <= pending_trials[0].random_fraction;
            offer_open = 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      site_trial_type t;
      if (!reset && req_bus.valid && req_bus.ready) begin
         t.row = req_bus.row;
         t.column = req_bus.column;
         t.random_fraction = req_bus.random_fraction;
         expected_outcomes.push_back(predict_trial(t));
         void'(pending_trials.pop_front());
         offer_open = 1'b0;
      end
   end

   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= !rsp_hold && $urandom_range(99) >= rsp_stall_pct;
   end

   // Response monitor: every response transaction is checked against the oldest prediction.
   always @(posedge clock) begin
      spin_outcome_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_outcomes.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTED)
               $display("unexpected response: flipped %0b new_spin %0b spin_total %0d",
                        rsp_bus.flipped, rsp_bus.new_spin, rsp_bus.spin_total);
         end else begin
            want = expected_outcomes.pop_front();
            if (rsp_bus.flipped !== want.flipped || rsp_bus.new_spin !== want.new_spin ||
                rsp_bus.spin_total !== want.spin_total) begin
               error_count++;
               if (error_count <= MAX_REPORTED)
                  $display({"response mismatch: expected flipped %0b new_spin %0b ",
                            "spin_total %0d, got flipped %0b new_spin %0b spin_total %0d"},
                           want.flipped, want.new_spin, want.spin_total,
                           rsp_bus.flipped, rsp_bus.new_spin, rsp_bus.spin_total);
            end
         end
      end
   end

   // Long response stall so that the block fills up and pushes back on requests.
   initial begin
      rsp_hold = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_hold = 1'b1;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      end
   end

   initial begin
      int side_plan [RANDOM_PHASES] = '{64, 4, KEEP_LATTICE, 2, KEEP_LATTICE, 7, 127, 32, 5};
      logic [FRACTION_W-1:0] low_draw, high_draw;

      reset = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_LATTICE_SIDE;
      csr_bus.data = '0;
      offer_open = 1'b0;
      hold_request = 1'b0;
      error_count = 0;
      accept_low = '0;
      accept_high = '0;
      restart_lattice(SIDE_CSR_W'(SIDE_RESET));
      send_idle_pct = 16;
      rsp_stall_pct = 70;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: thresholds of zero never accept an energy rise.
      queue_trial(0, 0, 16'h0000);
      queue_trial(63, 63, 16'h0000);
      queue_trial(0, 63, 16'hFFFF);
      drain_pipeline();

      write_register(CSR_THRESHOLD_LOW, 16'hFFFF);
      write_register(CSR_THRESHOLD_HIGH, 16'hFFFF);
      queue_trial(0, 0, 16'hFFFF);
      queue_trial(0, 0, 16'hFFFE);
      queue_trial(0, 1, 16'hFFFF);
      queue_trial(0, 1, 16'h0000);
      queue_trial(0, 0, 16'hFFFF);
      queue_trial(63, 0, 16'h0000);
      queue_trial(0, 63, 16'h0000);
      queue_trial(1, 0, 16'h0000);
      drain_pipeline();

      // Smallest side: each neighbor on an axis is the same site, counted twice.
      write_register(CSR_LATTICE_SIDE, 16'd2);
      write_register(CSR_THRESHOLD_LOW, 16'h0000);
      write_register(CSR_THRESHOLD_HIGH, 16'h8000);
      queue_trial(0, 0, 16'h8000);
      queue_trial(0, 0, 16'h7FFF);
      queue_trial(1, 1, 16'h0000);
      queue_trial(0, 1, 16'hFFFF);
      queue_trial(2, 0, 16'h0000);
      queue_trial(0, 2, 16'h0000);
      queue_trial(63, 63, 16'h0000);
      drain_pipeline();

      // Sides outside the legal range are clamped.
      write_register(CSR_LATTICE_SIDE, 16'd0);
      queue_trial(1, 0, 16'h0000);
      queue_trial(2, 2, 16'h0000);
      drain_pipeline();
      write_register(CSR_LATTICE_SIDE, 16'd1);
      queue_trial(1, 1, 16'h0000);
      drain_pipeline();
      write_register(CSR_LATTICE_SIDE, 16'd127);
      queue_trial(63, 63, 16'h0000);
      drain_pipeline();
      write_register(CSR_LATTICE_SIDE, 16'd3);
      queue_trial(2, 2, 16'h0000);
      queue_trial(3, 0, 16'h0000);
      drain_pipeline();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p / 3)
            0: begin
               send_idle_pct = 16;
               rsp_stall_pct = 70;
            end
            1: begin
               send_idle_pct = 70;
               rsp_stall_pct = 16;
            end
            default: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         if (side_plan[p] != KEEP_LATTICE)
            write_register(CSR_LATTICE_SIDE, CSR_DATA_W'(side_plan[p]));
         // Kept lattices get extreme thresholds: no uphill move, or any draw < 16'hFFFF.
         if (p == 2) begin
            low_draw = 16'h0000;
            high_draw = 16'h0000;
         end else if (p == 4) begin
            low_draw = 16'hFFFF;
            high_draw = 16'hFFFF;
         end else begin
            low_draw = FRACTION_W'($urandom_range(65535));
            high_draw = FRACTION_W'($urandom_range(low_draw));
         end
         write_register(CSR_THRESHOLD_LOW, low_draw);
         write_register(CSR_THRESHOLD_HIGH, high_draw);
         for (int chunk = 0; chunk < 2; chunk++) begin
            if ((p == 0 && chunk == 1) || (p == 6 && chunk == 0)) hold_request = 1'b1;
            repeat (TRIALS_PER_CHUNK) pending_trials.push_back(random_trial());
            // The drain between chunks pauses the sender until every response is in.
            drain_pipeline();
         end
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/ims_pkg.sv
rtl/ims_if.sv
rtl/ising_metropolis_spin_update.sv
tb/sv/tb_ising_metropolis_spin_update.sv
